### rtl/core/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg: shared constants and tables for the line voltage phasor core
// Holds the CORDIC arctangent table, fixed-point formats and scaling
// constants used by the front end, the CORDIC cells and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package plp_pkg;

  // Defaults for the top level parameters.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAG_WIDTH_DEF    = 16;

  // Fixed formats.
  localparam int ANG_W   = 15;   // degrees, 6 fraction bits
  localparam int GUARD   = 12;   // extra fraction bits inside the CORDIC
  localparam int X_EXTRA = 18;   // headroom over the magnitude for gain and sign
  localparam int ZW      = 34;   // binary angle, full turn is 2^32, with headroom
  localparam int TAB_LEN = 24;

  // Degrees to binary angle: ang * 2^23 / 45 = ang * Q_WHOLE + ang * Q_REM / 45.
  localparam int Q_WHOLE  = 186413;
  localparam int Q_REM    = 23;
  localparam int DIV_MUL  = 372827;  // floor(2^24 / 45)
  localparam int DIV_SH   = 24;
  localparam int DIV_DEN  = 45;

  // Binary angle to degrees.
  localparam int DEG_TURN = 23040;

  // RMS scale round(2^32 / (K^2 * sqrt 2)) split into two 16-bit halves.
  localparam longint LINE_SCALE = 64'd1119912543;
  localparam int SCALE_HI = int'(LINE_SCALE >> 16);
  localparam int SCALE_LO = int'(LINE_SCALE & 64'hFFFF);

  typedef logic signed [ZW-1:0] zang_t;

  // Arctangent of 2^-i as a binary angle.
  function automatic zang_t atan_val(input int idx);
    zang_t v;
    case (idx)
      0:       v = 34'sd536870912;
      1:       v = 34'sd316933406;
      2:       v = 34'sd167458907;
      3:       v = 34'sd85004756;
      4:       v = 34'sd42667331;
      5:       v = 34'sd21354465;
      6:       v = 34'sd10679838;
      7:       v = 34'sd5340245;
      8:       v = 34'sd2670163;
      9:       v = 34'sd1335087;
      10:      v = 34'sd667544;
      11:      v = 34'sd333772;
      12:      v = 34'sd166886;
      13:      v = 34'sd83443;
      14:      v = 34'sd41722;
      15:      v = 34'sd20861;
      16:      v = 34'sd10430;
      17:      v = 34'sd5215;
      18:      v = 34'sd2608;
      19:      v = 34'sd1304;
      20:      v = 34'sd652;
      21:      v = 34'sd326;
      22:      v = 34'sd163;
      23:      v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/core/plp_if.sv
// ----------------------------------------------------------------------------
// plp_if: valid/ready channels of the line voltage phasor core
// One channel carries the three phase phasors, the other the three line
// phasors. A word moves on a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface plp_in_if
  import plp_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [MAG_WIDTH-1:0]    phase_a_mag;
  logic signed [ANG_W-1:0] phase_a_ang;
  logic [MAG_WIDTH-1:0]    phase_b_mag;
  logic signed [ANG_W-1:0] phase_b_ang;
  logic [MAG_WIDTH-1:0]    phase_c_mag;
  logic signed [ANG_W-1:0] phase_c_ang;

  modport source (output valid, phase_a_mag, phase_a_ang, phase_b_mag, phase_b_ang,
                  phase_c_mag, phase_c_ang, input ready);
  modport sink   (input valid, phase_a_mag, phase_a_ang, phase_b_mag, phase_b_ang,
                  phase_c_mag, phase_c_ang, output ready);
endinterface

interface plp_out_if
  import plp_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [MAG_WIDTH-1:0]    line_ab_mag;
  logic signed [ANG_W-1:0] line_ab_ang;
  logic [MAG_WIDTH-1:0]    line_bc_mag;
  logic signed [ANG_W-1:0] line_bc_ang;
  logic [MAG_WIDTH-1:0]    line_ca_mag;
  logic signed [ANG_W-1:0] line_ca_ang;

  modport source (output valid, line_ab_mag, line_ab_ang, line_bc_mag, line_bc_ang,
                  line_ca_mag, line_ca_ang, input ready);
  modport sink   (input valid, line_ab_mag, line_ab_ang, line_bc_mag, line_bc_ang,
                  line_ca_mag, line_ca_ang, output ready);
endinterface

`default_nettype wire

### rtl/core/plp_front.sv
// ----------------------------------------------------------------------------
// plp_front: phasor entry stages
// Turns a degree angle into a binary angle over three pipeline stages,
// folds it into the right half plane and seeds the rotation CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_front
  import plp_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF,
  parameter int XW        = MAG_WIDTH_DEF + X_EXTRA
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [MAG_WIDTH-1:0]    mag,
  input  logic signed [ANG_W-1:0] ang,
  output logic signed [XW-1:0]    x,
  output logic signed [XW-1:0]    y,
  output zang_t                   z
);

  // Stage one: magnitude of the angle and the two partial products.
  logic [ANG_W-1:0]      a_abs;
  logic                  neg1;
  logic [32:0]           p1;
  logic [19:0]           n1;
  logic [MAG_WIDTH-1:0]  mag1;

  assign a_abs = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= ang[ANG_W-1];
      p1   <= 33'(a_abs) * 33'(Q_WHOLE);
      n1   <= 20'(a_abs) * 20'(Q_REM);
      mag1 <= mag;
    end
  end

  // Stage two: estimate of n / 45 by a reciprocal multiplication.
  logic [38:0]          prod;
  logic                 neg2;
  logic [32:0]          p2;
  logic [19:0]          n2;
  logic [13:0]          m2;
  logic [MAG_WIDTH-1:0] mag2;

  assign prod = 39'(n1) * 39'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      p2   <= p1;
      n2   <= n1;
      m2   <= prod[DIV_SH+13:DIV_SH];
      mag2 <= mag1;
    end
  end

  // Stage three: correct the quotient, apply the sign, wrap and fold.
  logic [19:0]         rem;
  logic [ZW-1:0]       q;
  logic [ZW-1:0]       zs;
  logic signed [31:0]  z32;
  logic                fold;
  logic signed [XW-1:0] xm;

  assign rem  = n2 - 20'(m2) * 20'(DIV_DEN);
  assign q    = ZW'(p2) + ZW'(m2) + ZW'(rem >= 20'(DIV_DEN));
  assign zs   = neg2 ? -q : q;
  assign z32  = signed'(zs[31:0]);
  assign fold = (z32 >= 32'sh40000000) || (z32 < -32'sh40000000);
  assign xm   = signed'(XW'({mag2, {GUARD{1'b0}}}));

  always_ff @(posedge clk) begin
    if (en) begin
      y <= '0;
      if (fold) begin
        x <= -xm;
        z <= z32[31] ? ZW'(z32) + zang_t'(34'sh80000000)
                     : ZW'(z32) - zang_t'(34'sh80000000);
      end else begin
        x <= xm;
        z <= ZW'(z32);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/plp_rot_cell.sv
// ----------------------------------------------------------------------------
// plp_rot_cell: one rotation-mode CORDIC step
// Rotates the vector by the fixed angle of its step towards the residual
// angle and hands the result to the next cell every cycle that the pipeline is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_rot_cell
  import plp_pkg::*;
#(
  parameter int XW  = MAG_WIDTH_DEF + X_EXTRA,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  zang_t                z_in,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output zang_t                z
);

  // Direction follows the sign of the residual angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x <= x_in - (y_in >>> IDX);
        y <= y_in + (x_in >>> IDX);
        z <= z_in - atan_val(IDX);
      end else begin
        x <= x_in + (y_in >>> IDX);
        y <= y_in - (x_in >>> IDX);
        z <= z_in + atan_val(IDX);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/plp_diff.sv
// ----------------------------------------------------------------------------
// plp_diff: line difference and vectoring entry
// Subtracts two rectangular phasors, marks an exactly zero difference and
// folds the left half plane over before the vectoring CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_diff
  import plp_pkg::*;
#(
  parameter int XW = MAG_WIDTH_DEF + X_EXTRA
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] xp,
  input  logic signed [XW-1:0] yp,
  input  logic signed [XW-1:0] xq,
  input  logic signed [XW-1:0] yq,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output zang_t                z,
  output logic                 zero
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 dz;

  // Difference stage.
  always_ff @(posedge clk) begin
    if (en) begin
      dx <= xp - xq;
      dy <= yp - yq;
      dz <= (xp == xq) && (yp == yq);
    end
  end

  // Half turn fold for a negative real part.
  always_ff @(posedge clk) begin
    if (en) begin
      zero <= dz;
      if (dx[XW-1]) begin
        x <= -dx;
        y <= -dy;
        z <= zang_t'(34'sh80000000);
      end else begin
        x <= dx;
        y <= dy;
        z <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/plp_vec_cell.sv
// ----------------------------------------------------------------------------
// plp_vec_cell: one vectoring-mode CORDIC step
// Drives the imaginary part towards zero, collecting the angle turned, and
// passes the zero-difference mark along with the vector.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_vec_cell
  import plp_pkg::*;
#(
  parameter int XW  = MAG_WIDTH_DEF + X_EXTRA,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  zang_t                z_in,
  input  logic                 zero_in,
  output logic signed [XW-1:0] x,
  output logic signed [XW-1:0] y,
  output zang_t                z,
  output logic                 zero
);

  // Direction follows the sign of the imaginary part.
  always_ff @(posedge clk) begin
    if (en) begin
      zero <= zero_in;
      if (!y_in[XW-1]) begin
        x <= x_in + (y_in >>> IDX);
        y <= y_in - (x_in >>> IDX);
        z <= z_in + atan_val(IDX);
      end else begin
        x <= x_in - (y_in >>> IDX);
        y <= y_in + (x_in >>> IDX);
        z <= z_in - atan_val(IDX);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/plp_back.sv
// ----------------------------------------------------------------------------
// plp_back: polar result stages
// Scales the CORDIC length to an RMS magnitude with rounding and saturation
// and turns the binary angle into rounded degrees. The second stage is the
// output register of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_back
  import plp_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF,
  parameter int XW        = MAG_WIDTH_DEF + X_EXTRA
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [XW-1:0]    x,
  input  zang_t                   z,
  input  logic                    zero,
  output logic [MAG_WIDTH-1:0]    mag,
  output logic signed [ANG_W-1:0] ang
);

  localparam int LW = XW - 1;
  localparam int VW = LW + 17;

  // Stage one: the three products.
  logic signed [31:0]   z32;
  logic [LW-1:0]        len;
  logic signed [46:0]   pz;
  logic [LW+14:0]       ph;
  logic [LW+15:0]       pl;
  logic                 zero1;

  assign z32 = signed'(z[31:0]);
  assign len = (x[XW-1] || (x == '0)) ? '0 : x[LW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pz    <= 47'(z32) * 47'(DEG_TURN);
      ph    <= (LW+15)'(len) * (LW+15)'(SCALE_HI);
      pl    <= (LW+16)'(len) * (LW+16)'(SCALE_LO);
      zero1 <= zero;
    end
  end

  // Stage two: rounding, saturation and the output register.
  logic signed [47:0] ps;
  logic [VW-1:0]      v;
  logic [VW-1:0]      r;

  assign ps = 48'(pz) + 48'sh80000000;
  assign v  = VW'(ph) + VW'(pl >> 16);
  assign r  = (v + (VW'(1) << (GUARD + 15))) >> (GUARD + 16);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero1) begin
        mag <= '0;
        ang <= '0;
      end else begin
        mag <= (|r[VW-1:MAG_WIDTH]) ? {MAG_WIDTH{1'b1}} : r[MAG_WIDTH-1:0];
        ang <= signed'(ps[32+ANG_W-1:32]);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/phase_to_line_voltage_phasors_core.sv
// ----------------------------------------------------------------------------
// phase_to_line_voltage_phasors_core: line voltage phasors from phase phasors
// Usage: one input word on "phasors" holds the peak magnitude and angle of
// phases A, B and C. For each word one output word on "lines" gives the RMS
// magnitude and angle of A-B, B-C and C-A, in the same order as accepted.
// Both channels use valid/ready; a word moves when both are high.
// Throughput: one word per cycle while the output is not stalled, since every
// CORDIC step is a cell of its own in a row of registers.
// Path from acceptance to valid output: the angle conversion stages, the
// rotation cells, one per CORDIC step up to 24, the difference and fold
// stages, the vectoring cells and the scaling stages into the output
// register.
// Stall: when an output word waits and ready is low, the whole pipeline
// holds and the input channel drops ready; the input stays ready as long as
// the output register is empty or being emptied.
// Reset: synchronous, clears every stage valid bit; data registers keep
// whatever they hold; words in flight are lost and none is produced by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_to_line_voltage_phasors_core
  import plp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int MAG_WIDTH    = MAG_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  plp_in_if.sink    phasors,
  plp_out_if.source lines
);

  localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int XW    = MAG_WIDTH + X_EXTRA;
  localparam int LAT   = 2 * NSTEP + 7;

  // Pipeline advance and stage valid bits.
  logic           en;
  logic [LAT-1:0] vld;

  assign en            = !vld[LAT-1] || lines.ready;
  assign phasors.ready = en;
  assign lines.valid   = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], phasors.valid};
    end
  end

  // Per phase input fields.
  logic [MAG_WIDTH-1:0]    in_mag [3];
  logic signed [ANG_W-1:0] in_ang [3];

  assign in_mag[0] = phasors.phase_a_mag;
  assign in_ang[0] = phasors.phase_a_ang;
  assign in_mag[1] = phasors.phase_b_mag;
  assign in_ang[1] = phasors.phase_b_ang;
  assign in_mag[2] = phasors.phase_c_mag;
  assign in_ang[2] = phasors.phase_c_ang;

  // Rotation chains, one per phase.
  logic signed [XW-1:0] rx [3][NSTEP+1];
  logic signed [XW-1:0] ry [3][NSTEP+1];
  zang_t                rz [3][NSTEP+1];

  // Vectoring chains, one per line.
  logic signed [XW-1:0] vx [3][NSTEP+1];
  logic signed [XW-1:0] vy [3][NSTEP+1];
  zang_t                vz [3][NSTEP+1];
  logic                 vzero [3][NSTEP+1];

  logic [MAG_WIDTH-1:0]    out_mag [3];
  logic signed [ANG_W-1:0] out_ang [3];

  for (genvar p = 0; p < 3; p++) begin : g_lane
    plp_front #(.MAG_WIDTH(MAG_WIDTH), .XW(XW)) u_front (
      .clk (clk),
      .en  (en),
      .mag (in_mag[p]),
      .ang (in_ang[p]),
      .x   (rx[p][0]),
      .y   (ry[p][0]),
      .z   (rz[p][0])
    );

    for (genvar i = 0; i < NSTEP; i++) begin : g_rot
      plp_rot_cell #(.XW(XW), .IDX(i)) u_cell (
        .clk  (clk),
        .en   (en),
        .x_in (rx[p][i]),
        .y_in (ry[p][i]),
        .z_in (rz[p][i]),
        .x    (rx[p][i+1]),
        .y    (ry[p][i+1]),
        .z    (rz[p][i+1])
      );
    end

    // Line p is phase p minus the next phase.
    plp_diff #(.XW(XW)) u_diff (
      .clk  (clk),
      .en   (en),
      .xp   (rx[p][NSTEP]),
      .yp   (ry[p][NSTEP]),
      .xq   (rx[(p+1)%3][NSTEP]),
      .yq   (ry[(p+1)%3][NSTEP]),
      .x    (vx[p][0]),
      .y    (vy[p][0]),
      .z    (vz[p][0]),
      .zero (vzero[p][0])
    );

    for (genvar i = 0; i < NSTEP; i++) begin : g_vec
      plp_vec_cell #(.XW(XW), .IDX(i)) u_cell (
        .clk     (clk),
        .en      (en),
        .x_in    (vx[p][i]),
        .y_in    (vy[p][i]),
        .z_in    (vz[p][i]),
        .zero_in (vzero[p][i]),
        .x       (vx[p][i+1]),
        .y       (vy[p][i+1]),
        .z       (vz[p][i+1]),
        .zero    (vzero[p][i+1])
      );
    end

    plp_back #(.MAG_WIDTH(MAG_WIDTH), .XW(XW)) u_back (
      .clk  (clk),
      .en   (en),
      .x    (vx[p][NSTEP]),
      .z    (vz[p][NSTEP]),
      .zero (vzero[p][NSTEP]),
      .mag  (out_mag[p]),
      .ang  (out_ang[p])
    );
  end

  assign lines.line_ab_mag = out_mag[0];
  assign lines.line_ab_ang = out_ang[0];
  assign lines.line_bc_mag = out_mag[1];
  assign lines.line_bc_ang = out_ang[1];
  assign lines.line_ca_mag = out_mag[2];
  assign lines.line_ca_ang = out_ang[2];

  // Checks on the pipeline control and on the angle range of lines AB and CA.
  a_rst_empty: assert property (@(posedge clk) rst |=> !lines.valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (lines.valid && !lines.ready) |=> (lines.valid && $stable(vld)))
    else $error("pipeline moved during an output stall");

  a_ab_range: assert property (@(posedge clk) disable iff (rst)
    lines.valid |-> (lines.line_ab_ang >= -15'sd11520 && lines.line_ab_ang <= 15'sd11520))
    else $error("line AB angle out of range");

  a_ca_range: assert property (@(posedge clk) disable iff (rst)
    lines.valid |-> (lines.line_ca_ang >= -15'sd11520 && lines.line_ca_ang <= 15'sd11520))
    else $error("line CA angle out of range");

endmodule

`default_nettype wire
